// File: src/ytr_pkg.sv
// ----------------------------------------------------------------------------
// ytr_pkg: shared types and arithmetic for the YUYV to RGB pair converter
// Q8 coefficients, the chroma term bundle and the clamp/scale helpers.
// ----------------------------------------------------------------------------
package ytr_pkg;

  localparam int unsigned PixW   = 8;
  localparam int unsigned CoefW  = 10;
  localparam int unsigned DiffW  = 10;
  localparam int unsigned SumW   = 11;
  localparam int unsigned ProdW  = 20;

  localparam logic [CoefW-1:0] CoefRv = 10'd292;
  localparam logic [CoefW-1:0] CoefGu = 10'd101;
  localparam logic [CoefW-1:0] CoefGv = 10'd149;
  localparam logic [CoefW-1:0] CoefBu = 10'd520;

  localparam logic signed [SumW-1:0] ChromaMid = 11'sd128;
  localparam logic signed [SumW-1:0] PixMax    = 11'sd255;

  // Chroma terms shared by both pixels of a macropixel.
  typedef struct packed {
    logic signed [DiffW-1:0] red_diff;
    logic signed [DiffW-1:0] blue_diff;
    logic [PixW-1:0]         green_term;
  } ytr_chroma_t;

  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
  } ytr_rgb_t;

  // coef * (c - 128) / 256, rounded toward zero.
  function automatic logic signed [DiffW-1:0] scaled(input logic [CoefW-1:0] coef,
                                                     input logic [PixW-1:0] c);
    logic signed [DiffW-1:0] d;
    logic signed [ProdW-1:0] p;
    logic signed [ProdW-1:0] q;
    d = $signed({2'b00, c}) - 10'sd128;
    p = ProdW'(d) * $signed({10'b0, coef});
    // Bias negative products so the arithmetic shift truncates toward zero.
    q = p + (p[ProdW-1] ? 20'sd255 : 20'sd0);
    q = q >>> 8;
    return q[DiffW-1:0];
  endfunction

  function automatic logic [PixW-1:0] clamp_pix(input logic signed [SumW-1:0] v);
    logic [PixW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > PixMax) begin
      r = '1;
    end else begin
      r = v[PixW-1:0];
    end
    return r;
  endfunction

endpackage

// File: src/ytr_chroma.sv
// ----------------------------------------------------------------------------
// ytr_chroma: shared chroma stage
// Forms the red, blue and clamped green chroma terms from U and V.
// ----------------------------------------------------------------------------
module ytr_chroma (
  input  logic                     clk,
  input  logic                     load,
  input  logic [ytr_pkg::PixW-1:0] chroma_blue,
  input  logic [ytr_pkg::PixW-1:0] chroma_red,
  output ytr_pkg::ytr_chroma_t     chroma
);
  import ytr_pkg::*;

  logic signed [DiffW-1:0] green_u;
  logic signed [DiffW-1:0] green_v;
  logic signed [SumW-1:0]  green_sum;
  ytr_chroma_t             chroma_next;

  always_comb begin
    green_u   = scaled(CoefGu, chroma_blue);
    green_v   = scaled(CoefGv, chroma_red);
    green_sum = ChromaMid - SumW'(green_u) - SumW'(green_v);
    chroma_next.red_diff   = scaled(CoefRv, chroma_red);
    chroma_next.blue_diff  = scaled(CoefBu, chroma_blue);
    chroma_next.green_term = clamp_pix(green_sum);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chroma <= chroma_next;
    end
  end

endmodule

// File: src/ytr_lane.sv
// ----------------------------------------------------------------------------
// ytr_lane: one pixel lane
// Adds the shared chroma terms to one luma value and clamps each channel.
// ----------------------------------------------------------------------------
module ytr_lane (
  input  logic [ytr_pkg::PixW-1:0] luma,
  input  ytr_pkg::ytr_chroma_t     chroma,
  output ytr_pkg::ytr_rgb_t        rgb
);
  import ytr_pkg::*;

  logic signed [SumW-1:0] y_ext;

  always_comb begin
    y_ext     = $signed({3'b000, luma});
    rgb.red   = clamp_pix(y_ext + SumW'(chroma.red_diff));
    rgb.blue  = clamp_pix(y_ext + SumW'(chroma.blue_diff));
    rgb.green = clamp_pix(y_ext + $signed({3'b000, chroma.green_term}) - ChromaMid);
  end

endmodule

// File: src/yuyv_to_rgb_pixel_pair.sv
// ----------------------------------------------------------------------------
// yuyv_to_rgb_pixel_pair: YUYV 4:2:2 macropixel to RGB888 pixel pair
// Two pixel lanes share one chroma stage; an output register merges them.
// ----------------------------------------------------------------------------
// One macropixel is taken per clock and one result comes out per clock while
// neither side stalls. Each transaction passes two register stages: the
// chroma products, then the per-pixel add and clamp in two parallel lanes.
// Both sides stall independently; the stages hold their data while the
// downstream is not ready.
module yuyv_to_rgb_pixel_pair (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // luma_first, chroma_blue, luma_second, chroma_red (8 bits each)
  input  logic [31:0] s_tdata,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // red_first, green_first, blue_first, red_second, green_second,
  // blue_second, gray_first, gray_second, chroma_blue, chroma_red
  output logic [79:0] m_tdata,
  output logic        m_tlast
);
  import ytr_pkg::*;

  logic            stage_valid;
  logic            stage_load;
  logic            out_load;
  logic [PixW-1:0] luma_first;
  logic [PixW-1:0] luma_second;
  logic [PixW-1:0] chroma_blue;
  logic [PixW-1:0] chroma_red;
  logic            frame_last;
  ytr_chroma_t     chroma;
  ytr_rgb_t        rgb_first;
  ytr_rgb_t        rgb_second;

  assign out_load   = stage_valid && (!m_tvalid || m_tready);
  assign s_tready   = !stage_valid || out_load;
  assign stage_load = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (s_tready) begin
        stage_valid <= s_tvalid;
      end
      if (!m_tvalid || m_tready) begin
        m_tvalid <= stage_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_load) begin
      luma_first  <= s_tdata[7:0];
      chroma_blue <= s_tdata[15:8];
      luma_second <= s_tdata[23:16];
      chroma_red  <= s_tdata[31:24];
      frame_last  <= s_tlast;
    end
  end

  ytr_chroma u_chroma (
    .clk         (clk),
    .load        (stage_load),
    .chroma_blue (s_tdata[15:8]),
    .chroma_red  (s_tdata[31:24]),
    .chroma      (chroma)
  );

  ytr_lane u_lane_first (
    .luma   (luma_first),
    .chroma (chroma),
    .rgb    (rgb_first)
  );

  ytr_lane u_lane_second (
    .luma   (luma_second),
    .chroma (chroma),
    .rgb    (rgb_second)
  );

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {chroma_red, chroma_blue, luma_second, luma_first,
                  rgb_second.blue, rgb_second.green, rgb_second.red,
                  rgb_first.blue, rgb_first.green, rgb_first.red};
      m_tlast <= frame_last;
    end
  end

endmodule
